### design/srdr_pkg.sv
// shared types and constants for the scan result dedup/rank table
// command and status structs between controller and datapath
// no dependencies
package srdr_pkg;

  // input opcodes, code 3 carries no meaning and is ignored
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_STORE  = 2'd1,
    OP_FINISH = 2'd2
  } opcode_e;

  // result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_STORE   = 2'd1,
    KIND_ENTRY   = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  // which result the output register is loaded with
  typedef enum logic [2:0] {
    OUT_CLEAR   = 3'd0,
    OUT_HIT     = 3'd1,
    OUT_NEW     = 3'd2,
    OUT_DROP    = 3'd3,
    OUT_ENTRY   = 3'd4,
    OUT_SUMMARY = 3'd5
  } out_sel_e;

  // table write source and address
  typedef enum logic [1:0] {
    WR_CUR_J  = 2'd0,
    WR_CUR_I  = 2'd1,
    WR_IN_J   = 2'd2,
    WR_IN_CNT = 2'd3
  } wr_src_e;

  // table read address
  typedef enum logic {
    RD_J = 1'b0,
    RD_I = 1'b1
  } rd_src_e;

  localparam logic [4:0] LimitReset = 5'd16;
  localparam logic [4:0] MaxShown   = 5'd16;
  localparam logic [4:0] CountSat   = 5'd31;

  // controller to datapath
  typedef struct packed {
    logic     take;
    logic     clr_count;
    logic     inc_count;
    logic     i_init;
    logic     i_inc;
    logic     j_clear;
    logic     j_from_i;
    logic     j_inc;
    logic     rd_en;
    rd_src_e  rd_src;
    logic     cur_load;
    logic     mem_we;
    wr_src_e  wr_src;
    logic     out_load;
    out_sel_e out_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e in_op;
    logic    j_end;
    logic    i_end_sort;
    logic    i_end_emit;
    logic    match;
    logic    greater;
    logic    full;
    logic    out_free;
  } dp_status_t;

endpackage

### design/srdr_dp.sv
// datapath: table memories, counters, running entry and output register
// depends on srdr_pkg
module srdr_dp #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srdr_pkg::dp_cmd_t   cmd_i,
  output srdr_pkg::dp_status_t status_o,
  input  logic                cfg_valid_i,
  input  logic [4:0]          cfg_data_i,
  input  logic [1:0]          opcode_i,
  input  logic [47:0]         device_address_i,
  input  logic signed [7:0]   signal_strength_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          result_kind_o,
  output logic [3:0]          slot_index_o,
  output logic                dropped_o,
  output logic [47:0]         entry_address_o,
  output logic signed [7:0]   entry_strength_o,
  output logic [4:0]          device_count_o,
  output logic [4:0]          shown_count_o,
  output logic                last_of_run_o
);
  import srdr_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (CW > 5) ? CW : 5;

  logic [47:0]       addr_mem [TABLE_DEPTH];
  logic signed [7:0] str_mem  [TABLE_DEPTH];

  logic [4:0]        limit_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     i_q;
  logic [CW-1:0]     j_q;
  logic [47:0]       in_addr_q;
  logic signed [7:0] in_str_q;
  logic [47:0]       rd_addr_q;
  logic signed [7:0] rd_str_q;
  logic [47:0]       cur_addr_q;
  logic signed [7:0] cur_str_q;

  logic              out_valid_q;
  logic [1:0]        kind_q;
  logic [3:0]        slot_q;
  logic              drop_q;
  logic [47:0]       oaddr_q;
  logic signed [7:0] ostr_q;
  logic [4:0]        dev_q;
  logic [4:0]        shown_q;
  logic              last_q;

  logic [1:0]        kind_d;
  logic [3:0]        slot_d;
  logic              drop_d;
  logic [47:0]       oaddr_d;
  logic signed [7:0] ostr_d;
  logic [4:0]        dev_d;
  logic [4:0]        shown_d;
  logic              last_d;

  logic [IW-1:0]     wr_idx;
  logic [47:0]       wr_addr;
  logic signed [7:0] wr_str;
  logic [IW-1:0]     rd_idx;
  logic [4:0]        lim;
  logic [XW-1:0]     count_x;
  logic [XW-1:0]     shown_x;
  logic [XW-1:0]     i_x;
  logic [XW-1:0]     j_x;
  logic [4:0]        dev_w;
  logic              out_free;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // entry count and loop indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.clr_count) begin
        count_q <= '0;
      end else if (cmd_i.inc_count) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.i_init) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + CW'(1);
      end
      if (cmd_i.j_clear) begin
        j_q <= '0;
      end else if (cmd_i.j_from_i) begin
        j_q <= i_q + CW'(1);
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + CW'(1);
      end
    end
  end

  // latched input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      in_addr_q <= device_address_i;
      in_str_q  <= signal_strength_i;
    end
  end

  // write port select
  always_comb begin
    case (cmd_i.wr_src)
      WR_CUR_J: begin
        wr_idx  = j_q[IW-1:0];
        wr_addr = cur_addr_q;
        wr_str  = cur_str_q;
      end
      WR_CUR_I: begin
        wr_idx  = i_q[IW-1:0];
        wr_addr = cur_addr_q;
        wr_str  = cur_str_q;
      end
      WR_IN_J: begin
        wr_idx  = j_q[IW-1:0];
        wr_addr = in_addr_q;
        wr_str  = in_str_q;
      end
      default: begin
        wr_idx  = count_q[IW-1:0];
        wr_addr = in_addr_q;
        wr_str  = in_str_q;
      end
    endcase
  end

  assign rd_idx = (cmd_i.rd_src == RD_I) ? i_q[IW-1:0] : j_q[IW-1:0];

  // table memories, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      addr_mem[wr_idx] <= wr_addr;
      str_mem[wr_idx]  <= wr_str;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_addr_q <= addr_mem[rd_idx];
      rd_str_q  <= str_mem[rd_idx];
    end
  end

  // running entry of the current sort row
  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load) begin
      cur_addr_q <= rd_addr_q;
      cur_str_q  <= rd_str_q;
    end
  end

  // limit clamp, shown count and saturated device count
  assign lim     = (limit_q == 5'd0 || limit_q > MaxShown) ? MaxShown : limit_q;
  assign count_x = XW'(count_q);
  assign i_x     = XW'(i_q);
  assign j_x     = XW'(j_q);
  assign shown_x = (count_x < XW'(lim)) ? count_x : XW'(lim);
  assign dev_w   = (count_x > XW'(CountSat)) ? CountSat : count_x[4:0];

  assign out_free = !out_valid_q || out_ready_i;

  // status to controller
  always_comb begin
    status_o.in_op      = opcode_e'(opcode_i);
    status_o.j_end      = (j_q >= count_q);
    status_o.i_end_sort = (i_q >= count_q);
    status_o.i_end_emit = (i_x >= shown_x);
    status_o.match      = (rd_addr_q == in_addr_q);
    status_o.greater    = (rd_str_q > cur_str_q);
    status_o.full       = (count_q == CW'(TABLE_DEPTH));
    status_o.out_free   = out_free;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // next output word, unused fields stay zero
  always_comb begin
    kind_d  = KIND_STORE;
    slot_d  = '0;
    drop_d  = 1'b0;
    oaddr_d = '0;
    ostr_d  = '0;
    dev_d   = '0;
    shown_d = '0;
    last_d  = 1'b1;
    case (cmd_i.out_sel)
      OUT_CLEAR: begin
        kind_d = KIND_CLEAR;
      end
      OUT_HIT: begin
        slot_d = j_x[3:0];
      end
      OUT_NEW: begin
        slot_d = count_x[3:0];
      end
      OUT_DROP: begin
        drop_d = 1'b1;
      end
      OUT_ENTRY: begin
        kind_d  = KIND_ENTRY;
        slot_d  = i_x[3:0];
        oaddr_d = rd_addr_q;
        ostr_d  = rd_str_q;
        last_d  = 1'b0;
      end
      default: begin
        kind_d  = KIND_SUMMARY;
        dev_d   = dev_w;
        shown_d = shown_x[4:0];
      end
    endcase
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q  <= kind_d;
      slot_q  <= slot_d;
      drop_q  <= drop_d;
      oaddr_q <= oaddr_d;
      ostr_q  <= ostr_d;
      dev_q   <= dev_d;
      shown_q <= shown_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign slot_index_o     = slot_q;
  assign dropped_o        = drop_q;
  assign entry_address_o  = oaddr_q;
  assign entry_strength_o = ostr_q;
  assign device_count_o   = dev_q;
  assign shown_count_o    = shown_q;
  assign last_of_run_o    = last_q;

endmodule

### design/srdr_ctrl.sv
// controller: sequences lookup, append, selection sort and ranked output
// depends on srdr_pkg
module srdr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  srdr_pkg::dp_status_t status_i,
  output srdr_pkg::dp_cmd_t    cmd_o
);
  import srdr_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_CLR   = 14'b00000000000010,
    ST_S_RD  = 14'b00000000000100,
    ST_S_CMP = 14'b00000000001000,
    ST_S_HIT = 14'b00000000010000,
    ST_S_END = 14'b00000000100000,
    ST_F_I   = 14'b00000001000000,
    ST_F_LD  = 14'b00000010000000,
    ST_F_RD  = 14'b00000100000000,
    ST_F_CMP = 14'b00001000000000,
    ST_F_WB  = 14'b00010000000000,
    ST_E_CHK = 14'b00100000000000,
    ST_E_OUT = 14'b01000000000000,
    ST_SUMM  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.take = take;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (status_i.in_op)
            OP_CLEAR: begin
              state_d = ST_CLR;
            end
            OP_STORE: begin
              cmd_o.j_clear = 1'b1;
              state_d = ST_S_RD;
            end
            OP_FINISH: begin
              cmd_o.i_init = 1'b1;
              state_d = ST_F_I;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      // clear done
      ST_CLR: begin
        if (status_i.out_free) begin
          cmd_o.clr_count = 1'b1;
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = OUT_CLEAR;
          state_d = ST_IDLE;
        end
      end
      // address lookup: read entry j, then compare it with the input address
      ST_S_RD: begin
        if (status_i.j_end) begin
          state_d = ST_S_END;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_J;
          state_d = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        if (status_i.match) begin
          state_d = ST_S_HIT;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d = ST_S_RD;
        end
      end
      // known address: update strength in place
      ST_S_HIT: begin
        if (status_i.out_free) begin
          cmd_o.mem_we   = 1'b1;
          cmd_o.wr_src   = WR_IN_J;
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_HIT;
          state_d = ST_IDLE;
        end
      end
      // new address: append or drop
      ST_S_END: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.full) begin
            cmd_o.out_sel = OUT_DROP;
          end else begin
            cmd_o.mem_we    = 1'b1;
            cmd_o.wr_src    = WR_IN_CNT;
            cmd_o.inc_count = 1'b1;
            cmd_o.out_sel   = OUT_NEW;
          end
          state_d = ST_IDLE;
        end
      end
      // sort row i: fetch entry i
      ST_F_I: begin
        if (status_i.i_end_sort) begin
          cmd_o.i_init = 1'b1;
          state_d = ST_E_CHK;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = RD_I;
          cmd_o.j_from_i = 1'b1;
          state_d = ST_F_LD;
        end
      end
      ST_F_LD: begin
        cmd_o.cur_load = 1'b1;
        state_d = ST_F_RD;
      end
      // sweep later entries, swap stronger ones into the running entry
      ST_F_RD: begin
        if (status_i.j_end) begin
          state_d = ST_F_WB;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_J;
          state_d = ST_F_CMP;
        end
      end
      ST_F_CMP: begin
        if (status_i.greater) begin
          cmd_o.mem_we   = 1'b1;
          cmd_o.wr_src   = WR_CUR_J;
          cmd_o.cur_load = 1'b1;
        end
        cmd_o.j_inc = 1'b1;
        state_d = ST_F_RD;
      end
      ST_F_WB: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_src = WR_CUR_I;
        cmd_o.i_inc  = 1'b1;
        state_d = ST_F_I;
      end
      // ranked entries in order
      ST_E_CHK: begin
        if (status_i.i_end_emit) begin
          state_d = ST_SUMM;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_I;
          state_d = ST_E_OUT;
        end
      end
      ST_E_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_ENTRY;
          cmd_o.i_inc    = 1'b1;
          state_d = ST_E_CHK;
        end
      end
      ST_SUMM: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_SUMMARY;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/scan_result_dedup_rank_table.sv
// Clear empties the table; store searches the held entries one by one, then updates
// a known address, appends a new one or drops it; finish ranks and emits the shown entries.
// Throughput: one word at a time, set by the single table read port; the next word
// is taken as soon as the last result sits in the output register; stalls delay it.
// Reset: entry count cleared, report limit 16, table contents left undefined
// (no clearing pass, entries beyond the count are never read).
// depends on srdr_pkg, srdr_ctrl, srdr_dp
module scan_result_dedup_rank_table_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [4:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [47:0]       device_address_i,
  input  logic signed [7:0] signal_strength_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        result_kind_o,
  output logic [3:0]        slot_index_o,
  output logic              dropped_o,
  output logic [47:0]       entry_address_o,
  output logic signed [7:0] entry_strength_o,
  output logic [4:0]        device_count_o,
  output logic [4:0]        shown_count_o,
  output logic              last_of_run_o
);
  import srdr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  srdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srdr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .device_address_i  (device_address_i),
    .signal_strength_i (signal_strength_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .result_kind_o     (result_kind_o),
    .slot_index_o      (slot_index_o),
    .dropped_o         (dropped_o),
    .entry_address_o   (entry_address_o),
    .entry_strength_o  (entry_strength_o),
    .device_count_o    (device_count_o),
    .shown_count_o     (shown_count_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule

### test/tb_top.sv
// testbench for scan_result_dedup_rank_table_core: directed table, then random scans
// checked word by word against a behavioral copy of the dedup table and rank sort
// depends on srdr_pkg and the core RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srdr_pkg::*;

  localparam int TableDepth  = 16;
  localparam int DirRows     = 25;
  localparam int NumPhases   = 7;
  localparam int PhaseWords  = 22;
  localparam int PoolSize    = 20;
  localparam int IdleGap     = 40;
  localparam int DrainCycles = 400;
  localparam int CycleLimit  = 1000000;

  localparam logic [1:0] OpUnused = 2'd3;

  // report limits visited by the random phases, extremes and out of range included
  localparam logic [4:0] LimitSeq [NumPhases] = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd5, 5'd17, 5'd2};

  // one result word as seen on the output channel
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic        drop;
    logic [47:0] addr;
    logic [7:0]  rssi;
    logic [4:0]  dev;
    logic [4:0]  shown;
    logic        last;
  } scan_result_t;

  // one input word, with a typed expectation when fixed is set
  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] addr;
    logic [7:0]  rssi;
    logic        fixed;
    logic [3:0]  slot;
    logic        drop;
    logic [4:0]  dev;
    logic [4:0]  shown;
  } scan_word_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [4:0]        cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        opcode;
  logic [47:0]       dev_addr;
  logic signed [7:0] dev_rssi;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        res_kind;
  logic [3:0]        res_slot;
  logic              res_drop;
  logic [47:0]       res_addr;
  logic signed [7:0] res_rssi;
  logic [4:0]        res_dev;
  logic [4:0]        res_shown;
  logic              res_last;

  // behavioral copy of the table and the limit register
  logic [47:0]       tbl_addr [TableDepth];
  logic signed [7:0] tbl_rssi [TableDepth];
  int                tbl_count;
  logic [4:0]        shown_limit;

  scan_result_t awaited_q [$];
  scan_result_t step_out [$];
  logic [47:0]  addr_pool [PoolSize];
  int           mismatches = 0;
  int           burst_left = 0;
  int unsigned  cycle_cnt = 0;

  scan_result_dedup_rank_table_core #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (opcode),
    .device_address_i (dev_addr),
    .signal_strength_i(dev_rssi),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_kind_o    (res_kind),
    .slot_index_o     (res_slot),
    .dropped_o        (res_drop),
    .entry_address_o  (res_addr),
    .entry_strength_o (res_rssi),
    .device_count_o   (res_dev),
    .shown_count_o    (res_shown),
    .last_of_run_o    (res_last)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // dedup lookup, append, drop and selection-with-swap ranking
  task automatic scan_table_step(input logic [1:0] op, input logic [47:0] addr,
                                 input logic [7:0] rssi);
    scan_result_t      r;
    logic [47:0]       t_addr;
    logic signed [7:0] t_rssi;
    int                held;
    int                lim;
    int                n_shown;
    bit                hit;
    step_out.delete();
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_CLEAR: begin
        tbl_count = 0;
        r.kind = KIND_CLEAR;
        step_out.push_back(r);
      end
      OP_STORE: begin
        r.kind = KIND_STORE;
        hit = 1'b0;
        for (int i = 0; i < tbl_count && !hit; i++) begin
          if (tbl_addr[i] == addr) begin
            tbl_rssi[i] = rssi;
            r.slot = 4'(i);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (tbl_count >= TableDepth) begin
            r.drop = 1'b1;
          end else begin
            tbl_addr[tbl_count] = addr;
            tbl_rssi[tbl_count] = rssi;
            r.slot = 4'(tbl_count);
            tbl_count++;
          end
        end
        step_out.push_back(r);
      end
      OP_FINISH: begin
        held = (tbl_count > TableDepth) ? TableDepth : tbl_count;
        lim = (shown_limit == 5'd0 || shown_limit > MaxShown) ? int'(MaxShown) : int'(shown_limit);
        n_shown = (held < lim) ? held : lim;
        // swap whenever a later entry is strictly stronger
        for (int i = 0; i < held; i++) begin
          for (int j = i + 1; j < held; j++) begin
            if (tbl_rssi[j] > tbl_rssi[i]) begin
              t_addr = tbl_addr[i];
              t_rssi = tbl_rssi[i];
              tbl_addr[i] = tbl_addr[j];
              tbl_rssi[i] = tbl_rssi[j];
              tbl_addr[j] = t_addr;
              tbl_rssi[j] = t_rssi;
            end
          end
        end
        for (int i = 0; i < n_shown; i++) begin
          r = '0;
          r.kind = KIND_ENTRY;
          r.slot = 4'(i);
          r.addr = tbl_addr[i];
          r.rssi = tbl_rssi[i];
          step_out.push_back(r);
        end
        r = '0;
        r.kind = KIND_SUMMARY;
        r.dev = (held > int'(CountSat)) ? CountSat : 5'(held);
        r.shown = 5'(n_shown);
        r.last = 1'b1;
        step_out.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic scan_word_t scan_word(input logic [1:0] op, input logic [47:0] addr,
                                           input logic [7:0] rssi, input logic fixed,
                                           input logic [3:0] slot, input logic drop,
                                           input logic [4:0] dev, input logic [4:0] shown);
    scan_word_t w;
    w.op = op;
    w.addr = addr;
    w.rssi = rssi;
    w.fixed = fixed;
    w.slot = slot;
    w.drop = drop;
    w.dev = dev;
    w.shown = shown;
    return w;
  endfunction

  // random store word, mostly from the address pool so duplicates hit
  function automatic scan_word_t store_word();
    scan_word_t w;
    w = '0;
    w.op = OP_STORE;
    if ($urandom_range(0, 2) != 0) w.addr = addr_pool[$urandom_range(0, PoolSize - 1)];
    else w.addr = 48'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: w.rssi = ($urandom_range(0, 1) != 0) ? 8'h7f : 8'h80;
      1: w.rssi = 8'(int'($urandom_range(0, 4)) - 60);
      default: w.rssi = 8'($urandom);
    endcase
    return w;
  endfunction

  // send one word in bursts with random gaps, then record what it should cause
  task automatic send_word(input scan_word_t w);
    scan_result_t want;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    opcode   <= w.op;
    dev_addr <= w.addr;
    dev_rssi <= w.rssi;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    scan_table_step(w.op, w.addr, w.rssi);
    if (w.fixed) begin
      want = '0;
      want.last = 1'b1;
      case (w.op)
        OP_CLEAR: want.kind = KIND_CLEAR;
        OP_STORE: begin
          want.kind = KIND_STORE;
          want.slot = w.slot;
          want.drop = w.drop;
        end
        default: begin
          want.kind = KIND_SUMMARY;
          want.dev = w.dev;
          want.shown = w.shown;
        end
      endcase
      awaited_q.push_back(want);
    end else begin
      foreach (step_out[k]) awaited_q.push_back(step_out[k]);
    end
  endtask

  // drain, let the core settle, then write the limit register
  task automatic write_limit(input logic [4:0] value);
    in_valid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (IdleGap) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shown_limit = value;
    burst_left = 0;
  endtask

  task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver stalls follow a rotating mask that changes now and then
  int          stall_left = 0;
  logic [15:0] stall_mask = 16'hffff;
  logic [3:0]  stall_pos = 4'd0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0: stall_mask = 16'hffff;
        1: stall_mask = 16'($urandom);
        2: stall_mask = 16'h0001;
        default: stall_mask = 16'h5a5f;
      endcase
    end
    stall_left--;
    out_ready <= stall_mask[stall_pos];
    stall_pos <= stall_pos + 4'd1;
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_q.size() == 0) begin
        $error("unexpected result word: kind %0d slot %0d", res_kind, res_slot);
        mismatches++;
      end else begin
        want = awaited_q.pop_front();
        check_field("result_kind", 48'(want.kind), 48'(res_kind));
        check_field("slot_index", 48'(want.slot), 48'(res_slot));
        check_field("dropped", 48'(want.drop), 48'(res_drop));
        check_field("entry_address", want.addr, res_addr);
        check_field("entry_strength", 48'(want.rssi), {40'd0, res_rssi});
        check_field("device_count", 48'(want.dev), 48'(res_dev));
        check_field("shown_count", 48'(want.shown), 48'(res_shown));
        check_field("last_of_run", 48'(want.last), 48'(res_last));
      end
    end
  end

  initial begin : stimulus
    scan_word_t dir_tbl [DirRows];
    scan_word_t w;
    int         counted;
    int         n;
    int         pick;
    logic [1:0] op;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 5'd0;
    in_valid = 1'b0;
    opcode = OP_CLEAR;
    dev_addr = 48'd0;
    dev_rssi = 8'sd0;
    tbl_count = 0;
    shown_limit = LimitReset;

    // directed words, run with the limit left at its reset value
    dir_tbl[0]  = scan_word(OP_FINISH, 48'h0, 8'sd0, 1'b1, 4'd0, 1'b0, 5'd0, 5'd0);
    dir_tbl[1]  = scan_word(OpUnused, 48'h0, 8'sd0, 1'b0, 4'd0, 1'b0, 5'd0, 5'd0);
    dir_tbl[2]  = scan_word(OP_STORE, 48'h0, -8'sd128, 1'b1, 4'd0, 1'b0, 5'd0, 5'd0);
    dir_tbl[3]  = scan_word(OP_STORE, 48'hffff_ffff_ffff, 8'sd127, 1'b1, 4'd1, 1'b0, 5'd0, 5'd0);
    dir_tbl[4]  = scan_word(OP_STORE, 48'h0, 8'sd0, 1'b1, 4'd0, 1'b0, 5'd0, 5'd0);
    dir_tbl[5]  = scan_word(OP_STORE, 48'h8000_0000_0000, -8'sd1, 1'b1, 4'd2, 1'b0, 5'd0, 5'd0);
    dir_tbl[6]  = scan_word(OP_STORE, 48'h0000_0000_0001, 8'sd1, 1'b1, 4'd3, 1'b0, 5'd0, 5'd0);
    dir_tbl[7]  = scan_word(OP_STORE, 48'h1234_5678_9abc, -8'sd40, 1'b1, 4'd4, 1'b0, 5'd0, 5'd0);
    dir_tbl[8]  = scan_word(OP_STORE, 48'h1234_5678_9abd, -8'sd40, 1'b1, 4'd5, 1'b0, 5'd0, 5'd0);
    dir_tbl[9]  = scan_word(OP_STORE, 48'h5555_5555_5555, -8'sd40, 1'b1, 4'd6, 1'b0, 5'd0, 5'd0);
    dir_tbl[10] = scan_word(OP_STORE, 48'haaaa_aaaa_aaaa, 8'sd127, 1'b1, 4'd7, 1'b0, 5'd0, 5'd0);
    dir_tbl[11] = scan_word(OP_STORE, 48'h0000_ffff_0000, -8'sd128, 1'b1, 4'd8, 1'b0, 5'd0, 5'd0);
    dir_tbl[12] = scan_word(OP_STORE, 48'hffff_0000_ffff, -8'sd70, 1'b1, 4'd9, 1'b0, 5'd0, 5'd0);
    dir_tbl[13] = scan_word(OP_STORE, 48'h0102_0304_0506, -8'sd55, 1'b1, 4'd10, 1'b0, 5'd0, 5'd0);
    dir_tbl[14] = scan_word(OP_STORE, 48'hc0de_0000_0001, 8'sd0, 1'b1, 4'd11, 1'b0, 5'd0, 5'd0);
    dir_tbl[15] = scan_word(OP_STORE, 48'h7fff_ffff_ffff, -8'sd90, 1'b1, 4'd12, 1'b0, 5'd0, 5'd0);
    dir_tbl[16] = scan_word(OP_STORE, 48'h0000_0000_0002, 8'sd10, 1'b1, 4'd13, 1'b0, 5'd0, 5'd0);
    dir_tbl[17] = scan_word(OP_STORE, 48'h0000_0000_0003, -8'sd40, 1'b1, 4'd14, 1'b0, 5'd0, 5'd0);
    dir_tbl[18] = scan_word(OP_STORE, 48'h0000_0000_0004, 8'sd64, 1'b1, 4'd15, 1'b0, 5'd0, 5'd0);
    // table full: new address is dropped, known address still updates
    dir_tbl[19] = scan_word(OP_STORE, 48'h0000_0000_0005, 8'sd5, 1'b1, 4'd0, 1'b1, 5'd0, 5'd0);
    dir_tbl[20] = scan_word(OP_STORE, 48'h0000_0000_0004, -8'sd100, 1'b0, 4'd0, 1'b0, 5'd0, 5'd0);
    dir_tbl[21] = scan_word(OpUnused, 48'hffff_ffff_ffff, -8'sd1, 1'b0, 4'd0, 1'b0, 5'd0, 5'd0);
    dir_tbl[22] = scan_word(OP_FINISH, 48'h0, 8'sd0, 1'b0, 4'd0, 1'b0, 5'd0, 5'd0);
    dir_tbl[23] = scan_word(OP_CLEAR, 48'h0, 8'sd0, 1'b1, 4'd0, 1'b0, 5'd0, 5'd0);
    dir_tbl[24] = scan_word(OP_FINISH, 48'h0, 8'sd0, 1'b1, 4'd0, 1'b0, 5'd0, 5'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DirRows; k++) send_word(dir_tbl[k]);

    // random phases, one limit setting each
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_limit(LimitSeq[ph]);
      counted = 0;
      while (counted < PhaseWords) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // well-formed scan: clear, stores, finish
          foreach (addr_pool[p]) addr_pool[p] = 48'({$urandom, $urandom});
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 12);
          send_word(scan_word(OP_CLEAR, 48'({$urandom, $urandom}), 8'($urandom),
                              1'b0, 4'd0, 1'b0, 5'd0, 5'd0));
          repeat (n) send_word(store_word());
          send_word(scan_word(OP_FINISH, 48'({$urandom, $urandom}), 8'($urandom),
                              1'b0, 4'd0, 1'b0, 5'd0, 5'd0));
          counted += n + 2;
        end else if (pick < 9) begin
          // broken sequence: any opcode in any order
          repeat ($urandom_range(1, 4)) begin
            op = 2'($urandom_range(0, 3));
            w = store_word();
            w.op = op;
            send_word(w);
            if (op != OpUnused) counted++;
          end
        end else begin
          // noise word that the core ignores
          w = store_word();
          w.op = OpUnused;
          send_word(w);
        end
      end
    end

    // drain and watch for stray words
    in_valid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
